/* rtl/tql_pkg.sv */
// Shared types and constants for the tabular Q-learning step engine.
// No dependencies; imported by tabular_q_learning_step.
package tql_pkg;

	// default sizes handed to the top level
	localparam int DEF_MAX_STATES  = 64;
	localparam int DEF_MAX_ACTIONS = 8;
	localparam int DEF_ALPHA_DEPTH = 1024;

	// fixed field widths
	localparam int NS_W    = 7;
	localparam int ACT_W   = 4;
	localparam int ALPHA_W = 17;
	localparam int TIME_W  = 48;
	localparam int PICK_W  = 8;
	localparam int PBIT_W  = 3;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;

	// opcodes
	localparam logic [2:0] OP_WR_TRANS     = 3'd0;
	localparam logic [2:0] OP_WR_Q         = 3'd1;
	localparam logic [2:0] OP_WR_REWARD    = 3'd2;
	localparam logic [2:0] OP_WR_ALPHA     = 3'd3;
	localparam logic [2:0] OP_SET_STATE    = 3'd4;
	localparam logic [2:0] OP_LEARN_GREEDY = 3'd5;
	localparam logic [2:0] OP_LEARN_GIVEN  = 3'd6;
	localparam logic [2:0] OP_READ_Q       = 3'd7;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_DISCOUNT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_EXPLORE  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_STATES   = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_ACTIONS  = 2'd3;

	localparam logic [15:0] GAMMA_RST   = 16'd32768;
	localparam logic [15:0] EPS_RST     = 16'd6554;
	localparam logic [6:0]  STATES_RST  = 7'd64;
	localparam logic [3:0]  ACTIONS_RST = 4'd8;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         state_index;
		logic [2:0]         action_index;
		logic [9:0]         alpha_index;
		logic signed [31:0] entry_value;
		logic [15:0]        random_fraction;
		logic [7:0]         random_pick;
		logic [30:0]        planning_time;
	} req_t;

	typedef struct packed {
		logic signed [NS_W-1:0]  next_state;
		logic signed [ACT_W-1:0] chosen_action;
		logic                    dead_end;
		logic signed [31:0]      read_value;
		logic [TIME_W-1:0]       total_completion_time;
	} rsp_t;

endpackage

/* rtl/tabular_q_learning_step.sv */
// Tabular Q-learning step engine: tables in synchronous RAMs, sequenced update.
// Depends on tql_pkg.
// One request in flight at a time; each gets exactly one response. The Q RAM has a
// single read port, which is walked one column per cycle over the current row (greedy
// learn only) and again over the next-state row, and the update uses two registered
// multiplies. An exploring greedy learn also works out a bitwise remainder and then
// searches for the chosen valid action. A new request is taken while the previous
// response still waits in the output register.
// The four tables are not cleared at reset; reading an unwritten entry gives junk.
module tabular_q_learning_step #(
	parameter int MAX_STATES  = tql_pkg::DEF_MAX_STATES,
	parameter int MAX_ACTIONS = tql_pkg::DEF_MAX_ACTIONS,
	parameter int ALPHA_DEPTH = tql_pkg::DEF_ALPHA_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  tql_pkg::req_t               req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output tql_pkg::rsp_t               rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tql_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tql_pkg::CFG_DW-1:0]  cfg_data
);
	import tql_pkg::*;

	localparam int SRW   = $clog2(MAX_STATES);
	localparam int TW    = SRW + 1;
	localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACW   = $clog2(MAX_ACTIONS);
	localparam int EAW   = $clog2(MAX_ACTIONS + 1);
	localparam int ESW   = $clog2(MAX_STATES + 1);
	localparam int ALW   = $clog2(ALPHA_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDQ  = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_PICK = 4'd4;
	localparam logic [3:0] ST_L0   = 4'd5;
	localparam logic [3:0] ST_L1   = 4'd6;
	localparam logic [3:0] ST_MAXS = 4'd7;
	localparam logic [3:0] ST_M1   = 4'd8;
	localparam logic [3:0] ST_M2   = 4'd9;
	localparam logic [3:0] ST_M3   = 4'd10;
	localparam logic [3:0] ST_M4   = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	// table RAMs
	logic signed [TW-1:0]  tr_mem [0:DEPTH-1];
	logic signed [31:0]    q_mem  [0:DEPTH-1];
	logic signed [31:0]    rw_mem [0:DEPTH-1];
	logic [ALPHA_W-1:0]    al_mem [0:ALPHA_DEPTH-1];

	logic signed [TW-1:0]  tr_rd;
	logic signed [31:0]    q_rd, rw_rd;
	logic [ALPHA_W-1:0]    al_rd;
	logic [AW-1:0]         tr_ra, q_ra, q_wa;
	logic signed [31:0]    q_wd;
	logic                  tr_we, q_we, rw_we, al_we;
	logic signed [TW-1:0]  tr_wd;
	logic [ALPHA_W-1:0]    al_wd;

	// control and datapath registers
	logic [3:0]            st_q;
	req_t                  req_q;
	logic [15:0]           gamma_q, eps_q;
	logic [6:0]            nstates_q;
	logic [3:0]            nact_q;
	logic signed [TW-1:0]  cur_q;
	logic [TIME_W-1:0]     ct_q;
	logic [ALW-1:0]        step_q;
	logic [EAW-1:0]        ji_q, cnt_q;
	logic                  scan_v_s1;
	logic [ACW-1:0]        scan_col_s1;
	logic [SRW-1:0]        row_q;
	logic [MAX_ACTIONS-1:0] vmask_q;
	logic [ACW-1:0]        bcol_q, act_q;
	logic                  bvalid_q;
	logic signed [31:0]    bq_q, qold_q;
	logic [EAW:0]          rem_q;
	logic [PBIT_W-1:0]     dbit_q;
	logic [AW-1:0]         la_q;
	logic [SRW-1:0]        nxt_q;
	logic signed [33:0]    rwd_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic signed [48:0]    prod1_s1;
	logic signed [34:0]    delta_q;
	logic signed [52:0]    prod2_s1;
	logic signed [NS_W-1:0]  res_ns_q;
	logic signed [ACT_W-1:0] res_act_q;
	logic                  res_dead_q;
	logic signed [31:0]    res_qv_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_data_q;

	// combinational
	logic [ESW-1:0]        eff_states;
	logic [EAW-1:0]        eff_actions;
	logic                  tr_valid, cur_ok, in_addr_ok, accept, scan_issue;
	logic [AW-1:0]         in_la, scan_addr, best_la;
	logic signed [TW-1:0]  new_cur;
	logic [EAW:0]          rem_sh;
	logic [48:0]           ct_sum;
	logic signed [48:0]    g_rnd;
	logic signed [52:0]    p2_rnd;
	logic signed [37:0]    nq_wide;
	logic signed [31:0]    nq;

	assign cfg_ready = 1'b1;
	assign req_stall = (st_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// clamp the size registers to the built table shape
	always_comb begin
		if (nstates_q == '0)
			eff_states = ESW'(1);
		else if (32'(nstates_q) > MAX_STATES)
			eff_states = ESW'(MAX_STATES);
		else
			eff_states = ESW'(nstates_q);
		if (nact_q == '0)
			eff_actions = EAW'(1);
		else if (32'(nact_q) > MAX_ACTIONS)
			eff_actions = EAW'(MAX_ACTIONS);
		else
			eff_actions = EAW'(nact_q);
	end

	assign tr_valid   = !tr_rd[TW-1] && (32'(tr_rd[SRW-1:0]) < 32'(eff_states));
	assign cur_ok     = !cur_q[TW-1] && (32'(cur_q[SRW-1:0]) < 32'(eff_states));
	assign in_addr_ok = (32'(req_data.state_index) < MAX_STATES) &&
	                    (32'(req_data.action_index) < MAX_ACTIONS);
	assign in_la      = AW'(32'(req_data.state_index) * MAX_ACTIONS +
	                        32'(req_data.action_index));
	assign scan_addr  = AW'(32'(row_q) * MAX_ACTIONS + 32'(ji_q));
	assign best_la    = AW'(32'(row_q) * MAX_ACTIONS + 32'(bcol_q));
	assign scan_issue = (ji_q < eff_actions);
	assign new_cur    = (32'(req_data.state_index) < 32'(eff_states)) ?
	                    TW'(req_data.state_index) : '1;
	assign rem_sh     = {rem_q[EAW-1:0], req_q.random_pick[dbit_q]};
	assign ct_sum     = {1'b0, ct_q} + 49'(req_q.planning_time);

	// rounding: add half then floor
	assign g_rnd   = (prod1_s1 + 49'sd32768) >>> 16;
	assign p2_rnd  = (prod2_s1 + 53'sd32768) >>> 16;
	assign nq_wide = 38'(qold_q) + 38'(p2_rnd);
	always_comb begin
		if (nq_wide > 38'sd2147483647)
			nq = 32'sh7FFFFFFF;
		else if (nq_wide < -38'sd2147483648)
			nq = 32'sh80000000;
		else
			nq = nq_wide[31:0];
	end

	// RAM ports
	always_comb begin
		case (st_q)
			ST_IDLE:          q_ra = in_la;
			ST_SCAN, ST_MAXS: q_ra = scan_addr;
			default:          q_ra = la_q;
		endcase
		tr_ra = (st_q == ST_SCAN) ? scan_addr : la_q;

		tr_we = accept && (req_data.opcode == OP_WR_TRANS) && in_addr_ok;
		tr_wd = (!req_data.entry_value[31] && req_data.entry_value < MAX_STATES) ?
		        TW'(req_data.entry_value) : '1;
		rw_we = accept && (req_data.opcode == OP_WR_REWARD) && in_addr_ok;
		al_we = accept && (req_data.opcode == OP_WR_ALPHA) &&
		        (32'(req_data.alpha_index) < ALPHA_DEPTH);
		if (req_data.entry_value[31])
			al_wd = '0;
		else if (req_data.entry_value > 32'sd131071)
			al_wd = ALPHA_MAX;
		else
			al_wd = ALPHA_W'(req_data.entry_value);

		if (st_q == ST_M4) begin
			q_we = 1'b1;
			q_wa = la_q;
			q_wd = nq;
		end else begin
			q_we = accept && (req_data.opcode == OP_WR_Q) && in_addr_ok;
			q_wa = in_la;
			q_wd = req_data.entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (tr_we)
			tr_mem[in_la] <= tr_wd;
		tr_rd <= tr_mem[tr_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_wa] <= q_wd;
		q_rd <= q_mem[q_ra];
	end

	always_ff @(posedge clk) begin
		if (rw_we)
			rw_mem[in_la] <= req_data.entry_value;
		rw_rd <= rw_mem[la_q];
	end

	always_ff @(posedge clk) begin
		if (al_we)
			al_mem[ALW'(req_data.alpha_index)] <= al_wd;
		al_rd <= al_mem[step_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			req_q       <= '0;
			gamma_q     <= GAMMA_RST;
			eps_q       <= EPS_RST;
			nstates_q   <= STATES_RST;
			nact_q      <= ACTIONS_RST;
			cur_q       <= '0;
			ct_q        <= '0;
			step_q      <= '0;
			ji_q        <= '0;
			cnt_q       <= '0;
			scan_v_s1   <= 1'b0;
			scan_col_s1 <= '0;
			row_q       <= '0;
			vmask_q     <= '0;
			bcol_q      <= '0;
			act_q       <= '0;
			bvalid_q    <= 1'b0;
			bq_q        <= '0;
			qold_q      <= '0;
			rem_q       <= '0;
			dbit_q      <= '0;
			la_q        <= '0;
			nxt_q       <= '0;
			rwd_q       <= '0;
			alpha_q     <= '0;
			prod1_s1    <= '0;
			delta_q     <= '0;
			prod2_s1    <= '0;
			res_ns_q    <= '0;
			res_act_q   <= '0;
			res_dead_q  <= 1'b0;
			res_qv_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DISCOUNT: gamma_q   <= cfg_data;
					CFG_EXPLORE:  eps_q     <= cfg_data;
					CFG_STATES:   nstates_q <= cfg_data[6:0];
					CFG_ACTIONS:  nact_q    <= cfg_data[3:0];
					default:      ;
				endcase
			end

			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						req_q      <= req_data;
						res_ns_q   <= NS_W'(cur_q);
						res_act_q  <= '0;
						res_dead_q <= 1'b0;
						res_qv_q   <= '0;
						st_q       <= ST_DONE;
						case (req_data.opcode)
							OP_SET_STATE: begin
								cur_q    <= new_cur;
								res_ns_q <= NS_W'(new_cur);
							end
							OP_READ_Q: begin
								if (in_addr_ok)
									st_q <= ST_RDQ;
							end
							OP_LEARN_GREEDY: begin
								if (cur_ok) begin
									row_q     <= cur_q[SRW-1:0];
									ji_q      <= '0;
									cnt_q     <= '0;
									vmask_q   <= '0;
									scan_v_s1 <= 1'b0;
									st_q      <= ST_SCAN;
								end else begin
									// no usable current state
									ct_q       <= '0;
									cur_q      <= '1;
									res_ns_q   <= '1;
									res_act_q  <= '1;
									res_dead_q <= 1'b1;
								end
							end
							OP_LEARN_GIVEN: begin
								if (32'(req_data.state_index) < 32'(eff_states) &&
								    32'(req_data.action_index) < 32'(eff_actions)) begin
									la_q  <= in_la;
									act_q <= ACW'(req_data.action_index);
									st_q  <= ST_L0;
								end else begin
									ct_q       <= '0;
									res_ns_q   <= '1;
									res_act_q  <= '1;
									res_dead_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end

				ST_RDQ: begin
					res_qv_q <= q_rd;
					st_q     <= ST_DONE;
				end

				// walk the current row: count valid actions, note best valid Q
				ST_SCAN: begin
					if (scan_issue)
						ji_q <= ji_q + 1'b1;
					scan_v_s1   <= scan_issue;
					scan_col_s1 <= ACW'(ji_q);
					if (scan_v_s1) begin
						if (tr_valid) begin
							cnt_q <= cnt_q + 1'b1;
							vmask_q[scan_col_s1] <= 1'b1;
						end
						if (scan_col_s1 == '0) begin
							bcol_q   <= '0;
							bvalid_q <= tr_valid;
							bq_q     <= q_rd;
						end else if (tr_valid && (!bvalid_q || q_rd > bq_q)) begin
							bcol_q   <= scan_col_s1;
							bvalid_q <= 1'b1;
							bq_q     <= q_rd;
						end
					end
					if (!scan_issue && !scan_v_s1) begin
						if (cnt_q == '0) begin
							ct_q       <= '0;
							cur_q      <= '1;
							res_ns_q   <= '1;
							res_act_q  <= '1;
							res_dead_q <= 1'b1;
							st_q       <= ST_DONE;
						end else if (req_q.random_fraction <= eps_q) begin
							rem_q  <= '0;
							dbit_q <= PBIT_W'(PICK_W - 1);
							st_q   <= ST_DIV;
						end else begin
							act_q <= bcol_q;
							la_q  <= best_la;
							st_q  <= ST_L0;
						end
					end
				end

				// pick mod count, one bit per cycle
				ST_DIV: begin
					if (rem_sh >= {1'b0, cnt_q})
						rem_q <= rem_sh - {1'b0, cnt_q};
					else
						rem_q <= rem_sh;
					if (dbit_q == '0) begin
						ji_q <= '0;
						st_q <= ST_PICK;
					end else begin
						dbit_q <= dbit_q - 1'b1;
					end
				end

				// find the k-th valid column
				ST_PICK: begin
					ji_q <= ji_q + 1'b1;
					if (vmask_q[ACW'(ji_q)]) begin
						if (rem_q == '0) begin
							act_q <= ACW'(ji_q);
							la_q  <= scan_addr;
							st_q  <= ST_L0;
						end else begin
							rem_q <= rem_q - 1'b1;
						end
					end
				end

				ST_L0: st_q <= ST_L1;

				ST_L1: begin
					if (!tr_valid) begin
						ct_q       <= '0;
						res_ns_q   <= '1;
						res_act_q  <= '1;
						res_dead_q <= 1'b1;
						if (req_q.opcode == OP_LEARN_GREEDY)
							cur_q <= '1;
						st_q <= ST_DONE;
					end else begin
						nxt_q     <= tr_rd[SRW-1:0];
						row_q     <= tr_rd[SRW-1:0];
						rwd_q     <= 34'(rw_rd) - $signed({3'b000, req_q.planning_time});
						qold_q    <= q_rd;
						alpha_q   <= al_rd;
						ct_q      <= ct_sum[TIME_W] ? '1 : ct_sum[TIME_W-1:0];
						ji_q      <= '0;
						scan_v_s1 <= 1'b0;
						st_q      <= ST_MAXS;
					end
				end

				// max Q over the next-state row
				ST_MAXS: begin
					if (scan_issue)
						ji_q <= ji_q + 1'b1;
					scan_v_s1   <= scan_issue;
					scan_col_s1 <= ACW'(ji_q);
					if (scan_v_s1) begin
						if (scan_col_s1 == '0 || q_rd > bq_q)
							bq_q <= q_rd;
					end
					if (!scan_issue && !scan_v_s1)
						st_q <= ST_M1;
				end

				ST_M1: begin
					prod1_s1 <= $signed({1'b0, gamma_q}) * bq_q;
					st_q     <= ST_M2;
				end

				ST_M2: begin
					delta_q <= 35'(rwd_q) + 35'(g_rnd) - 35'(qold_q);
					st_q    <= ST_M3;
				end

				ST_M3: begin
					prod2_s1 <= $signed({1'b0, alpha_q}) * delta_q;
					st_q     <= ST_M4;
				end

				// write back the new Q (RAM write in the port block)
				ST_M4: begin
					if (step_q != ALW'(ALPHA_DEPTH - 1))
						step_q <= step_q + 1'b1;
					res_ns_q   <= NS_W'(nxt_q);
					res_act_q  <= ACT_W'(act_q);
					res_dead_q <= 1'b0;
					res_qv_q   <= nq;
					if (req_q.opcode == OP_LEARN_GREEDY)
						cur_q <= $signed({1'b0, nxt_q});
					st_q <= ST_DONE;
				end

				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q                      <= 1'b1;
						rsp_data_q.next_state            <= res_ns_q;
						rsp_data_q.chosen_action         <= res_act_q;
						rsp_data_q.dead_end              <= res_dead_q;
						rsp_data_q.read_value            <= res_qv_q;
						rsp_data_q.total_completion_time <= ct_q;
						st_q                             <= ST_IDLE;
					end
				end

				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
